FILE: design/obb_pkg.sv
package obb_pkg;

    localparam int OBB_COORD_W      = 32;
    localparam int OBB_TRIG_W       = 16;
    localparam int OBB_CENTER_SHIFT = 16;
    localparam int OBB_STAGES       = 7;

endpackage

FILE: design/obb_box.sv
module obb_box import obb_pkg::*; #(
    parameter int CW = OBB_COORD_W
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [CW-1:0]           i_cx,
    input  logic signed [CW-1:0]           i_cy,
    input  logic        [CW-2:0]           i_w,
    input  logic        [CW-2:0]           i_h,
    input  logic signed [OBB_TRIG_W-1:0]   i_c,
    input  logic signed [OBB_TRIG_W-1:0]   i_s,
    output logic signed [CW+17:0]          o_kx [4],
    output logic signed [CW+17:0]          o_ky [4],
    output logic signed [OBB_TRIG_W-1:0]   o_c,
    output logic signed [OBB_TRIG_W-1:0]   o_s,
    output logic        [CW+31:0]          o_lim_w,
    output logic        [CW+31:0]          o_lim_h,
    output logic                           o_deg
);
    localparam int TW = OBB_TRIG_W;
    localparam int PW = CW + OBB_CENTER_SHIFT;
    localparam int KW = CW + 18;
    localparam int LW = CW + 32;
    localparam int QW = 2 * TW;

    logic signed [PW-1:0] n_cw, n_sw, n_ch, n_sh;
    logic signed [QW:0]   n_len2;
    logic signed [PW-1:0] r_cw, r_sw, r_ch, r_sh, r_cx, r_cy;
    logic        [CW-2:0] r_w, r_h;
    logic signed [TW-1:0] r_c, r_s;
    logic        [QW-1:0] r_len2;
    logic                 r_deg;

    logic signed [KW-1:0] n_kx [4];
    logic signed [KW-1:0] n_ky [4];
    logic        [LW-2:0] n_pw, n_ph;
    logic signed [KW-1:0] r_kx [4];
    logic signed [KW-1:0] r_ky [4];
    logic signed [TW-1:0] r_c2, r_s2;
    logic        [LW-1:0] r_lim_w, r_lim_h;
    logic                 r_deg2;

    always_comb begin
        n_cw   = i_c * $signed({1'b0, i_w});
        n_sw   = i_s * $signed({1'b0, i_w});
        n_ch   = i_c * $signed({1'b0, i_h});
        n_sh   = i_s * $signed({1'b0, i_h});
        n_len2 = i_c * i_c + i_s * i_s;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cw   <= n_cw;
            r_sw   <= n_sw;
            r_ch   <= n_ch;
            r_sh   <= n_sh;
            r_cx   <= {i_cx, {OBB_CENTER_SHIFT{1'b0}}};
            r_cy   <= {i_cy, {OBB_CENTER_SHIFT{1'b0}}};
            r_w    <= i_w;
            r_h    <= i_h;
            r_c    <= i_c;
            r_s    <= i_s;
            r_len2 <= n_len2[QW-1:0];
            r_deg  <= (i_w == '0) || (i_h == '0) || ((i_c == '0) && (i_s == '0));
        end
    end

    // k0 = C-hx-hy, k1 = C+hx-hy, k2 = C+hx+hy, k3 = C-hx+hy
    always_comb begin
        n_kx[0] = KW'(r_cx) - KW'(r_cw) + KW'(r_sh);
        n_ky[0] = KW'(r_cy) - KW'(r_sw) - KW'(r_ch);
        n_kx[1] = KW'(r_cx) + KW'(r_cw) + KW'(r_sh);
        n_ky[1] = KW'(r_cy) + KW'(r_sw) - KW'(r_ch);
        n_kx[2] = KW'(r_cx) + KW'(r_cw) - KW'(r_sh);
        n_ky[2] = KW'(r_cy) + KW'(r_sw) + KW'(r_ch);
        n_kx[3] = KW'(r_cx) - KW'(r_cw) - KW'(r_sh);
        n_ky[3] = KW'(r_cy) - KW'(r_sw) + KW'(r_ch);
        n_pw    = (LW-1)'(r_w) * (LW-1)'(r_len2);
        n_ph    = (LW-1)'(r_h) * (LW-1)'(r_len2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_kx[k] <= n_kx[k];
                r_ky[k] <= n_ky[k];
            end
            r_c2    <= r_c;
            r_s2    <= r_s;
            r_lim_w <= {n_pw, 1'b0};
            r_lim_h <= {n_ph, 1'b0};
            r_deg2  <= r_deg;
        end
    end

    assign o_kx    = r_kx;
    assign o_ky    = r_ky;
    assign o_c     = r_c2;
    assign o_s     = r_s2;
    assign o_lim_w = r_lim_w;
    assign o_lim_h = r_lim_h;
    assign o_deg   = r_deg2;

endmodule

FILE: design/obb_axis.sv
module obb_axis import obb_pkg::*; #(
    parameter int CW = OBB_COORD_W
) (
    input  logic                           i_clk,
    input  logic                           i_en,
    input  logic signed [CW+17:0]          i_pkx,
    input  logic signed [CW+17:0]          i_pky,
    input  logic signed [CW+17:0]          i_qx [4],
    input  logic signed [CW+17:0]          i_qy [4],
    input  logic signed [OBB_TRIG_W-1:0]   i_c,
    input  logic signed [OBB_TRIG_W-1:0]   i_s,
    input  logic        [CW+31:0]          i_lim_w,
    input  logic        [CW+31:0]          i_lim_h,
    output logic                           o_pass
);
    localparam int TW = OBB_TRIG_W;
    localparam int KW = CW + 18;
    localparam int DW = KW + 1;
    localparam int AW = TW + 1;
    localparam int PW = DW + AW;
    localparam int SW = PW + 1;
    localparam int LW = CW + 32;

    logic signed [DW-1:0] r_dx [4];
    logic signed [DW-1:0] r_dy [4];
    logic signed [AW-1:0] r_ax [2];
    logic signed [AW-1:0] r_ay [2];
    logic        [LW-1:0] r_lim3 [2];

    logic signed [PW-1:0] r_px [2][4];
    logic signed [PW-1:0] r_py [2][4];
    logic        [LW-1:0] r_lim4 [2];

    logic signed [SW-1:0] r_t [2][4];
    logic        [LW-1:0] r_lim5 [2];

    logic signed [SW-1:0] n_min [2];
    logic signed [SW-1:0] n_max [2];
    logic signed [SW-1:0] n_lo0, n_lo1, n_hi0, n_hi1;
    logic signed [SW-1:0] r_min [2];
    logic signed [SW-1:0] r_max [2];
    logic        [LW-1:0] r_lim6 [2];

    logic                 n_pass;
    logic                 r_pass;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < 4; k++) begin
                r_dx[k] <= DW'(i_qx[k]) - DW'(i_pkx);
                r_dy[k] <= DW'(i_qy[k]) - DW'(i_pky);
            end
            r_ax[0]   <= AW'(i_c);
            r_ay[0]   <= AW'(i_s);
            r_ax[1]   <= -AW'(i_s);
            r_ay[1]   <= AW'(i_c);
            r_lim3[0] <= i_lim_w;
            r_lim3[1] <= i_lim_h;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 2; a++) begin
                for (int k = 0; k < 4; k++) begin
                    r_px[a][k] <= r_dx[k] * r_ax[a];
                    r_py[a][k] <= r_dy[k] * r_ay[a];
                end
                r_lim4[a] <= r_lim3[a];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 2; a++) begin
                for (int k = 0; k < 4; k++) begin
                    r_t[a][k] <= SW'(r_px[a][k]) + SW'(r_py[a][k]);
                end
                r_lim5[a] <= r_lim4[a];
            end
        end
    end

    always_comb begin
        for (int a = 0; a < 2; a++) begin
            n_lo0    = (r_t[a][0] < r_t[a][1]) ? r_t[a][0] : r_t[a][1];
            n_lo1    = (r_t[a][2] < r_t[a][3]) ? r_t[a][2] : r_t[a][3];
            n_hi0    = (r_t[a][0] < r_t[a][1]) ? r_t[a][1] : r_t[a][0];
            n_hi1    = (r_t[a][2] < r_t[a][3]) ? r_t[a][3] : r_t[a][2];
            n_min[a] = (n_lo0 < n_lo1) ? n_lo0 : n_lo1;
            n_max[a] = (n_hi0 < n_hi1) ? n_hi1 : n_hi0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int a = 0; a < 2; a++) begin
                r_min[a]  <= n_min[a];
                r_max[a]  <= n_max[a];
                r_lim6[a] <= r_lim5[a];
            end
        end
    end

    // axis passes when span [min,max] meets [0, lim]
    always_comb begin
        n_pass = 1'b1;
        for (int a = 0; a < 2; a++) begin
            if ((r_min[a] > $signed({{(SW-LW){1'b0}}, r_lim6[a]})) || (r_max[a] < 0)) begin
                n_pass = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pass <= n_pass;
        end
    end

    assign o_pass = r_pass;

endmodule

FILE: design/oriented_box_overlap_test_unit.sv
// Depth: 7 register stages lie between input transfer and the earliest result transfer.
// Throughput: one box pair per cycle; i_stall with o_valid set holds the whole pipeline.
// The depth is set by product, corner, offset, projection, sum, min/max and compare stages.
// Reset (synchronous, active low) clears the stage valid bits only.
module oriented_box_overlap_test_unit import obb_pkg::*; #(
    parameter int COORD_WIDTH = OBB_COORD_W
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic signed [COORD_WIDTH-1:0]   i_a_center_x,
    input  logic signed [COORD_WIDTH-1:0]   i_a_center_y,
    input  logic        [COORD_WIDTH-2:0]   i_a_width,
    input  logic        [COORD_WIDTH-2:0]   i_a_height,
    input  logic signed [OBB_TRIG_W-1:0]    i_a_cos,
    input  logic signed [OBB_TRIG_W-1:0]    i_a_sin,
    input  logic signed [COORD_WIDTH-1:0]   i_b_center_x,
    input  logic signed [COORD_WIDTH-1:0]   i_b_center_y,
    input  logic        [COORD_WIDTH-2:0]   i_b_width,
    input  logic        [COORD_WIDTH-2:0]   i_b_height,
    input  logic signed [OBB_TRIG_W-1:0]    i_b_cos,
    input  logic signed [OBB_TRIG_W-1:0]    i_b_sin,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic                            o_overlap,
    output logic                            o_degenerate
);
    localparam int CW = COORD_WIDTH;
    localparam int KW = CW + 18;
    localparam int LW = CW + 32;
    localparam int DD = OBB_STAGES - 2;

    logic                 w_en;
    logic [OBB_STAGES-1:0] r_vld;
    logic [DD-1:0]        r_deg;

    logic signed [KW-1:0] w_akx [4];
    logic signed [KW-1:0] w_aky [4];
    logic signed [KW-1:0] w_bkx [4];
    logic signed [KW-1:0] w_bky [4];
    logic signed [OBB_TRIG_W-1:0] w_ac, w_as, w_bc, w_bs;
    logic [LW-1:0]        w_alw, w_alh, w_blw, w_blh;
    logic                 w_adeg, w_bdeg, w_pass_ab, w_pass_ba;

    assign w_en    = !(r_vld[OBB_STAGES-1] && i_stall);
    assign o_stall = !w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[OBB_STAGES-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_deg <= {r_deg[DD-2:0], w_adeg || w_bdeg};
        end
    end

    obb_box #(.CW(CW)) u_box_a (
        .i_clk(i_clk), .i_en(w_en),
        .i_cx(i_a_center_x), .i_cy(i_a_center_y),
        .i_w(i_a_width), .i_h(i_a_height), .i_c(i_a_cos), .i_s(i_a_sin),
        .o_kx(w_akx), .o_ky(w_aky), .o_c(w_ac), .o_s(w_as),
        .o_lim_w(w_alw), .o_lim_h(w_alh), .o_deg(w_adeg)
    );

    obb_box #(.CW(CW)) u_box_b (
        .i_clk(i_clk), .i_en(w_en),
        .i_cx(i_b_center_x), .i_cy(i_b_center_y),
        .i_w(i_b_width), .i_h(i_b_height), .i_c(i_b_cos), .i_s(i_b_sin),
        .o_kx(w_bkx), .o_ky(w_bky), .o_c(w_bc), .o_s(w_bs),
        .o_lim_w(w_blw), .o_lim_h(w_blh), .o_deg(w_bdeg)
    );

    obb_axis #(.CW(CW)) u_axis_ab (
        .i_clk(i_clk), .i_en(w_en),
        .i_pkx(w_akx[0]), .i_pky(w_aky[0]), .i_qx(w_bkx), .i_qy(w_bky),
        .i_c(w_ac), .i_s(w_as), .i_lim_w(w_alw), .i_lim_h(w_alh),
        .o_pass(w_pass_ab)
    );

    obb_axis #(.CW(CW)) u_axis_ba (
        .i_clk(i_clk), .i_en(w_en),
        .i_pkx(w_bkx[0]), .i_pky(w_bky[0]), .i_qx(w_akx), .i_qy(w_aky),
        .i_c(w_bc), .i_s(w_bs), .i_lim_w(w_blw), .i_lim_h(w_blh),
        .o_pass(w_pass_ba)
    );

    assign o_valid      = r_vld[OBB_STAGES-1];
    assign o_degenerate = r_deg[DD-1];
    assign o_overlap    = w_pass_ab && w_pass_ba && !r_deg[DD-1];

endmodule

FILE: dv/oriented_box_overlap_test_unit_tb.sv
module oriented_box_overlap_test_unit_tb;
    import obb_pkg::*;

    localparam int CW = OBB_COORD_W;
    localparam int TW = OBB_TRIG_W;
    localparam int N_RANDOM = 650;
    localparam int N_DIRECTED = 16;

    typedef struct packed {
        logic signed [CW-1:0] cx;
        logic signed [CW-1:0] cy;
        logic [CW-2:0]        w;
        logic [CW-2:0]        h;
        logic signed [TW-1:0] c;
        logic signed [TW-1:0] s;
    } box_t;

    typedef struct packed {
        logic overlap;
        logic degenerate;
    } verdict_t;

    typedef struct packed {
        box_t     a;
        box_t     b;
        logic     known;
        verdict_t v;
    } vector_t;

    logic i_clk, i_rst_n, i_valid, i_stall;
    logic o_stall, o_valid, o_overlap, o_degenerate;
    box_t in_a, in_b;

    verdict_t expected_q[$];
    int  n_errors;
    logic stimulus_done;
    logic long_hold;

    oriented_box_overlap_test_unit i_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_stall(o_stall),
        .i_a_center_x(in_a.cx), .i_a_center_y(in_a.cy), .i_a_width(in_a.w),
        .i_a_height(in_a.h), .i_a_cos(in_a.c), .i_a_sin(in_a.s),
        .i_b_center_x(in_b.cx), .i_b_center_y(in_b.cy), .i_b_width(in_b.w),
        .i_b_height(in_b.h), .i_b_cos(in_b.c), .i_b_sin(in_b.s),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_overlap(o_overlap), .o_degenerate(o_degenerate)
    );

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Corner in units of 2^-16; k index 0..3 as C -+ hx -+ hy.
    function automatic void corners(input box_t b, output logic signed [127:0] kx[4],
                                    output logic signed [127:0] ky[4]);
        logic signed [127:0] cx, cy, cw, sw, ch, sh, w, h;
        cx = $signed(b.cx) * 128'sd65536;
        cy = $signed(b.cy) * 128'sd65536;
        w = $signed({97'd0, b.w});
        h = $signed({97'd0, b.h});
        cw = $signed(b.c) * w;
        sw = $signed(b.s) * w;
        ch = $signed(b.c) * h;
        sh = $signed(b.s) * h;
        kx[0] = cx - cw + sh; ky[0] = cy - sw - ch;
        kx[1] = cx + cw + sh; ky[1] = cy + sw - ch;
        kx[2] = cx + cw - sh; ky[2] = cy + sw + ch;
        kx[3] = cx - cw - sh; ky[3] = cy - sw + ch;
    endfunction

    function automatic logic no_separating_axis(input box_t p, input box_t q);
        logic signed [127:0] pkx[4], pky[4], qkx[4], qky[4];
        logic signed [127:0] len2, ax, ay, lim, t, tmin, tmax;
        corners(p, pkx, pky);
        corners(q, qkx, qky);
        len2 = $signed(p.c) * $signed(p.c) + $signed(p.s) * $signed(p.s);
        for (int a = 0; a < 2; a++) begin
            ax = a ? -$signed(p.s) : $signed(p.c);
            ay = a ? $signed(p.c) : $signed(p.s);
            lim = 128'sd2 * $signed({97'd0, a ? p.h : p.w}) * len2;
            tmin = 0;
            tmax = 0;
            for (int k = 0; k < 4; k++) begin
                t = (qkx[k] - pkx[0]) * ax + (qky[k] - pky[0]) * ay;
                if (k == 0) begin
                    tmin = t;
                    tmax = t;
                end else if (t < tmin) begin
                    tmin = t;
                end else if (t > tmax) begin
                    tmax = t;
                end
            end
            if (lim < tmin || tmax < 0) return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic verdict_t predict_overlap(input box_t a, input box_t b);
        verdict_t v;
        v.degenerate = (a.w == 0) || (a.h == 0) || (a.c == 0 && a.s == 0) ||
                       (b.w == 0) || (b.h == 0) || (b.c == 0 && b.s == 0);
        v.overlap = !v.degenerate && no_separating_axis(a, b) &&
                    no_separating_axis(b, a);
        return v;
    endfunction

    function automatic box_t mk(input int cx, input int cy, input int w, input int h,
                                input int c, input int s);
        box_t b;
        b.cx = cx; b.cy = cy; b.w = (CW-1)'(w); b.h = (CW-1)'(h);
        b.c = TW'(c); b.s = TW'(s);
        return b;
    endfunction

    function automatic box_t random_box(input logic near);
        box_t b;
        int ang;
        if (near) begin
            b.cx = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            b.cy = $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
            b.w = (CW-1)'($urandom_range(1, 32'h0004_0000));
            b.h = (CW-1)'($urandom_range(1, 32'h0004_0000));
            ang = $urandom_range(0, 7);
            case ($urandom_range(0, 2))
                0: begin b.c = TW'($urandom); b.s = TW'($urandom); end
                1: begin
                    b.c = TW'((ang[0]) ? 23170 : ((ang[1]) ? 32767 : 0));
                    b.s = TW'((ang[0]) ? 23170 : ((ang[1]) ? 0 : 32767));
                    if (ang[2]) b.c = -b.c;
                end
                default: begin
                    b.c = TW'($signed($urandom_range(0, 65534)) - 32767);
                    b.s = TW'($signed($urandom_range(0, 65534)) - 32767);
                end
            endcase
            if ($urandom_range(0, 40) == 0) b.w = 0;
            if ($urandom_range(0, 40) == 0) b.h = 0;
        end else begin
            b.cx = $urandom; b.cy = $urandom;
            b.w = (CW-1)'($urandom); b.h = (CW-1)'($urandom);
            b.c = TW'($urandom); b.s = TW'($urandom);
        end
        return b;
    endfunction

    vector_t directed[N_DIRECTED];

    initial begin
        directed[0] = '{mk(0, 0, 0, 65536, 32767, 0), mk(0, 0, 65536, 65536, 32767, 0),
                        1'b1, '{1'b0, 1'b1}};
        directed[1] = '{mk(0, 0, 65536, 0, 32767, 0), mk(0, 0, 65536, 65536, 32767, 0),
                        1'b1, '{1'b0, 1'b1}};
        directed[2] = '{mk(0, 0, 65536, 65536, 0, 0), mk(0, 0, 65536, 65536, 32767, 0),
                        1'b1, '{1'b0, 1'b1}};
        directed[3] = '{mk(0, 0, 65536, 65536, 32767, 0), mk(0, 0, 65536, 0, 0, 0),
                        1'b1, '{1'b0, 1'b1}};
        directed[4] = '{mk(0, 0, 65536, 65536, 32767, 0), mk(0, 0, 65536, 65536, 32767, 0),
                        1'b1, '{1'b1, 1'b0}};
        directed[5] = '{mk(0, 0, 65536, 65536, 32767, 0),
                        mk(32'h0100_0000, 0, 65536, 65536, 32767, 0), 1'b1, '{1'b0, 1'b0}};
        // side by side, apart along x
        directed[6] = '{mk(0, 0, 65536, 65536, 32767, 0),
                        mk(131072, 0, 65536, 65536, 32767, 0), 1'b0, '0};
        directed[7] = '{mk(0, 0, 65536, 65536, 23170, 23170),
                        mk(100000, 100000, 65536, 65536, -23170, 23170), 1'b0, '0};
        directed[8] = '{mk(32'sh7fffffff, 32'sh7fffffff, 31'h7fffffff, 31'h7fffffff,
                           -32768, -32768),
                        mk(32'sh80000000, 32'sh80000000, 31'h7fffffff, 31'h7fffffff,
                           32767, 32767), 1'b0, '0};
        directed[9] = '{mk(32'sh80000000, 0, 1, 1, -32768, 0),
                        mk(32'sh7fffffff, 0, 1, 1, 0, -32768), 1'b0, '0};
        // non-unit rotation
        directed[10] = '{mk(0, 0, 65536, 65536, 1, 0), mk(65536, 0, 65536, 65536, 3, 4),
                         1'b0, '0};
        directed[11] = '{mk(0, 0, 65536, 65536, 0, 32767), mk(0, 0, 1, 1, 0, -1),
                         1'b0, '0};
        directed[12] = '{mk(-65536, -65536, 1, 1, 32767, 0), mk(-65536, -65536, 1, 1, 32767, 0),
                         1'b0, '0};
        directed[13] = '{mk(0, 0, 31'h7fffffff, 1, 32767, 0), mk(0, 0, 1, 31'h7fffffff, 0, 32767),
                         1'b0, '0};
        directed[14] = '{mk(0, 0, 65536, 65536, 32767, 0), mk(0, 0, 65536, 65536, 0, 0),
                         1'b1, '{1'b0, 1'b1}};
        directed[15] = '{mk(-1, -1, 65536, 65536, -1, -1), mk(0, 0, 65536, 65536, 1, 1),
                         1'b0, '0};
    end

    task automatic send_transfer(input box_t a, input box_t b, input logic known,
                                 input verdict_t v);
        int gap;
        verdict_t p;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_a <= a;
        in_b <= b;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (o_stall);
        p = predict_overlap(a, b);
        if (known && p !== v) begin
            $error("directed row: expected %0b%0b predictor %0b%0b",
                   v.overlap, v.degenerate, p.overlap, p.degenerate);
            n_errors++;
        end
        expected_q.push_back(known ? v : p);
    endtask

    initial begin
        i_rst_n = 0;
        i_valid = 0;
        in_a = '0;
        in_b = '0;
        stimulus_done = 0;
        long_hold = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < N_DIRECTED; i++)
            send_transfer(directed[i].a, directed[i].b, directed[i].known, directed[i].v);
        for (int i = 0; i < N_RANDOM; i++) begin
            logic near;
            if (i == 200) long_hold <= 1'b1;
            if (i == 400) begin
                i_valid <= 1'b0;
                wait (expected_q.size() == 0);
            end
            near = $urandom_range(0, 9) != 0;
            send_transfer(random_box(near), random_box(near), 1'b0, '0);
        end
        i_valid <= 1'b0;
        stimulus_done = 1;
    end

    // receiver stall process
    initial begin
        int gap;
        i_stall = 1'b1;
        @(posedge i_rst_n);
        forever begin
            if (long_hold) begin
                i_stall <= 1'b1;
                repeat (300) @(posedge i_clk);
                long_hold <= 1'b0;
            end
            gap = $urandom_range(0, 2) == 0 ? 0 : $urandom_range(0, 18);
            if (gap == 0) begin
                i_stall <= 1'b0;
                @(posedge i_clk);
            end else begin
                i_stall <= 1'b1;
                repeat (gap) @(posedge i_clk);
                i_stall <= 1'b0;
                do @(posedge i_clk); while (!o_valid && !long_hold);
            end
        end
    end

    always @(posedge i_clk) begin
        verdict_t e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_q.size() == 0) begin
                $error("unexpected result transfer");
                n_errors++;
            end else begin
                e = expected_q.pop_front();
                if (o_overlap !== e.overlap) begin
                    $error("overlap: expected %0b actual %0b", e.overlap, o_overlap);
                    n_errors++;
                end
                if (o_degenerate !== e.degenerate) begin
                    $error("degenerate: expected %0b actual %0b", e.degenerate, o_degenerate);
                    n_errors++;
                end
            end
        end
    end

    initial begin
        n_errors = 0;
        wait (stimulus_done);
        wait (expected_q.size() == 0);
        repeat (4 * OBB_STAGES) @(posedge i_clk);
        if (n_errors == 0 && expected_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule
